FILE: hdl/bank_switch_cartridge_mapper_unit_macros.svh
// ---------------------------------------------------------------------------
// Bank switch cartridge mapper: assertion macros
// Shared concurrent assertion shorthands, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BANK_SWITCH_CARTRIDGE_MAPPER_UNIT_MACROS_SVH
`define BANK_SWITCH_CARTRIDGE_MAPPER_UNIT_MACROS_SVH

// Same-cycle implication
`define BSCM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define BSCM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bscm_pkg.sv
// ---------------------------------------------------------------------------
// Bank switch cartridge mapper: package
// Widths, command/target/mirroring/variant codes, port decodes, control
// structs and the ROM size mask helper.
// ---------------------------------------------------------------------------
package bscm_pkg;

  // Width of the translated byte offset
  localparam int ROM_OFFSET_BITS = 21;
  typedef logic [ROM_OFFSET_BITS-1:0] offset_t;

  // Commands
  localparam logic [1:0] CMD_WRITE    = 2'd0;
  localparam logic [1:0] CMD_CPU_READ = 2'd1;
  localparam logic [1:0] CMD_PPU_READ = 2'd2;

  // Targets
  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_PRG_ROM = 2'd1;
  localparam logic [1:0] TGT_PRG_RAM = 2'd2;
  localparam logic [1:0] TGT_CHR_ROM = 2'd3;

  // Mirroring modes
  localparam logic [2:0] MIR_VERTICAL     = 3'd0;
  localparam logic [2:0] MIR_HORIZONTAL   = 3'd1;
  localparam logic [2:0] MIR_SINGLE_LOWER = 3'd2;
  localparam logic [2:0] MIR_SINGLE_UPPER = 3'd3;
  localparam logic [2:0] MIR_CUSTOM       = 3'd4;

  // Board variants
  localparam logic [2:0] VAR_206 = 3'd0;
  localparam logic [2:0] VAR_76  = 3'd1;
  localparam logic [2:0] VAR_88  = 3'd2;
  localparam logic [2:0] VAR_95  = 3'd3;
  localparam logic [2:0] VAR_112 = 3'd4;
  localparam logic [2:0] VAR_154 = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_VARIANT         = 2'd0;
  localparam logic [1:0] CFG_CHR_SIZE_LOG2   = 2'd1;
  localparam logic [1:0] CFG_PRG_SIZE_LOG2   = 2'd2;
  localparam logic [1:0] CFG_PRG_RAM_PRESENT = 2'd3;

  // CPU write port decode
  localparam logic [15:0] PORT_MASK   = 16'hE001;
  localparam logic [15:0] PORT_SELECT = 16'h8000;
  localparam logic [15:0] PORT_DATA   = 16'h8001;
  localparam logic [15:0] PORT_A000   = 16'hA000;
  localparam logic [15:0] PORT_C000   = 16'hC000;
  localparam logic [15:0] PORT_E000   = 16'hE000;

  // Fixed-bank distances below the end of program ROM
  localparam offset_t PRG_FIX_LOW  = offset_t'(32'h4000);
  localparam offset_t PRG_FIX_HIGH = offset_t'(32'h2000);

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted item
    logic commit;   // update state and load the result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free; // result register empty or draining this cycle
  } ctl_status_t;

  // Mask of a ROM of 2**lg bytes, lg clamped to lo..ROM_OFFSET_BITS
  function automatic offset_t size_mask(input logic [4:0] lg, input logic [4:0] lo);
    logic [4:0] lg_c;
    lg_c = lg;
    if (lg_c < lo) lg_c = lo;
    if (lg_c > 5'(ROM_OFFSET_BITS)) lg_c = 5'(ROM_OFFSET_BITS);
    return ~({ROM_OFFSET_BITS{1'b1}} << lg_c);
  endfunction

endpackage

FILE: hdl/bscm_if.sv
// ---------------------------------------------------------------------------
// Bank switch cartridge mapper: channel interfaces
// Request (bus access) and response (translation) valid/ready channels.
// ---------------------------------------------------------------------------
interface bscm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, command, address, data, input ready);
  modport sink   (input valid, command, address, data, output ready);
endinterface

interface bscm_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [bscm_pkg::ROM_OFFSET_BITS-1:0] rom_offset;
  logic [1:0]                          target;
  logic [2:0]                          mirror_mode;
  logic                                nt_top_select;
  logic                                nt_bottom_select;

  modport source (output valid, rom_offset, target, mirror_mode, nt_top_select,
                  nt_bottom_select, input ready);
  modport sink   (input valid, rom_offset, target, mirror_mode, nt_top_select,
                  nt_bottom_select, output ready);
endinterface

FILE: hdl/bscm_ctrl.sv
// ---------------------------------------------------------------------------
// Bank switch cartridge mapper: controller
// Two-state sequencer: take an item, then commit it once the result
// register can accept it.
// ---------------------------------------------------------------------------
module bscm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  bscm_pkg::ctl_status_t status,
  output bscm_pkg::ctl_cmd_t    cmd
);
  import bscm_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  // Commands follow the state
  always_comb begin
    cmd.capture = in_ready && in_valid;
    cmd.commit  = (state == ST_EXEC) && status.out_free;
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state    <= ST_EXEC;
            in_ready <= 1'b0;
          end
        end
        ST_EXEC: begin
          if (status.out_free) begin
            state    <= ST_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= ST_IDLE;
          in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

FILE: hdl/bscm_datapath.sv
// ---------------------------------------------------------------------------
// Bank switch cartridge mapper: datapath
// Configuration, bank registers, write decode, address translation and the
// result register.
// ---------------------------------------------------------------------------
module bscm_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bscm_pkg::ctl_cmd_t                   cmd,
  output bscm_pkg::ctl_status_t                status,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [4:0]                           cfg_data,
  input  logic [1:0]                           command,
  input  logic [15:0]                          address,
  input  logic [7:0]                           data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bscm_pkg::ROM_OFFSET_BITS-1:0] rom_offset,
  output logic [1:0]                           target,
  output logic [2:0]                           mirror_mode,
  output logic                                 nt_top_select,
  output logic                                 nt_bottom_select
);
  import bscm_pkg::*;

  // Configuration
  logic [2:0] variant;
  logic [4:0] chr_size_log2;
  logic [4:0] prg_size_log2;
  logic       prg_ram_present;

  // Latched item
  logic [1:0]  it_cmd;
  logic [15:0] it_addr;
  logic [7:0]  it_data;

  // Mapper state
  logic [2:0] bank_select,   bank_select_next;
  logic [8:0] chr_bank       [6];
  logic [8:0] chr_bank_next  [6];
  logic [7:0] prg_bank       [2];
  logic [7:0] prg_bank_next  [2];
  logic [3:0] chr_upper,     chr_upper_next;
  logic [1:0] nt_select,     nt_select_next;
  logic [2:0] mirror_state,  mirror_state_next;

  logic [2:0]  v;
  logic [15:0] port;
  logic        data_wr;
  logic [2:0]  sel;
  logic [2:0]  sel_m2;

  offset_t     pm, cm, prg_base, off;
  logic [1:0]  tgt;
  logic [2:0]  chr_idx;
  logic [10:0] chr_low;
  logic [8:0]  chr_sel_bank;

  assign status.out_free = !out_valid || out_ready;

  // Unlisted variants decode as 206
  assign v       = (variant > VAR_154) ? VAR_206 : variant;
  assign port    = it_addr & PORT_MASK;
  assign data_wr = (v == VAR_112) ? (port == PORT_A000) : (port == PORT_DATA);
  assign sel     = bank_select;
  assign sel_m2  = sel - 3'd2;

  // CPU write: next register state
  always_comb begin
    bank_select_next  = bank_select;
    chr_bank_next     = chr_bank;
    prg_bank_next     = prg_bank;
    chr_upper_next    = chr_upper;
    nt_select_next    = nt_select;
    mirror_state_next = mirror_state;
    if (it_cmd == CMD_WRITE) begin
      if (port == PORT_SELECT) bank_select_next = it_data[2:0];
      if (data_wr) begin
        if (v == VAR_112) begin
          if (sel < 3'd2) begin
            prg_bank_next[sel[0]] = it_data;
          end else if (sel < 3'd4) begin
            chr_bank_next[sel_m2] = {1'b0, it_data & 8'hFE};
          end else begin
            chr_bank_next[sel_m2] = {chr_upper[sel[1:0]], it_data};
          end
        end else if (sel >= 3'd6) begin
          prg_bank_next[sel[0]] = it_data;
        end else begin
          case (v)
            VAR_76: begin
              if (sel >= 3'd2) chr_bank_next[sel] = {it_data, 1'b0};
            end
            VAR_88, VAR_154: begin
              chr_bank_next[sel] = (sel < 3'd2) ? {1'b0, it_data & 8'h3E}
                                                : {1'b0, it_data | 8'h40};
            end
            default: begin
              chr_bank_next[sel] = (sel < 3'd2) ? {1'b0, it_data & 8'hFE}
                                                : {1'b0, it_data};
              if (v == VAR_95 && sel < 3'd2) nt_select_next[sel[0]] = it_data[5];
            end
          endcase
        end
      end
      if (v == VAR_112) begin
        if (port == PORT_C000) chr_upper_next = it_data[7:4];
        if (port == PORT_E000) mirror_state_next = it_data[0] ? MIR_HORIZONTAL
                                                              : MIR_VERTICAL;
      end
      if (v == VAR_154 && it_addr[15]) begin
        mirror_state_next = it_data[6] ? MIR_SINGLE_UPPER : MIR_SINGLE_LOWER;
      end
    end
  end

  // Read translation
  always_comb begin
    pm           = size_mask(prg_size_log2, 5'd14);
    cm           = size_mask(chr_size_log2, 5'd10);
    prg_base     = '0;
    chr_idx      = '0;
    chr_low      = '0;
    chr_sel_bank = '0;
    off          = '0;
    tgt          = TGT_NONE;
    case (it_cmd)
      CMD_CPU_READ: begin
        if (it_addr[15]) begin
          if (!it_addr[14]) begin
            prg_base = offset_t'({prg_bank[it_addr[13]], 13'b0});
          end else begin
            prg_base = pm + offset_t'(1) - (it_addr[13] ? PRG_FIX_HIGH : PRG_FIX_LOW);
          end
          off = (prg_base + offset_t'(it_addr[12:0])) & pm;
          tgt = TGT_PRG_ROM;
        end else if (it_addr[14:13] == 2'b11 && v == VAR_112 && prg_ram_present) begin
          off = offset_t'(it_addr[12:0]);
          tgt = TGT_PRG_RAM;
        end
      end
      CMD_PPU_READ: begin
        if (it_addr[15:13] == 3'b000) begin
          if (v == VAR_76) begin
            chr_idx = 3'd2 + {1'b0, it_addr[12:11]};
            chr_low = it_addr[10:0];
          end else if (!it_addr[12]) begin
            chr_idx = {2'b0, it_addr[11]};
            chr_low = it_addr[10:0];
          end else begin
            chr_idx = 3'd2 + {1'b0, it_addr[11:10]};
            chr_low = {1'b0, it_addr[9:0]};
          end
          chr_sel_bank = chr_bank[chr_idx];
          off = (offset_t'({chr_sel_bank, 10'b0}) + offset_t'(chr_low)) & cm;
          tgt = TGT_CHR_ROM;
        end
      end
      default: begin
        off = '0;
        tgt = TGT_NONE;
      end
    endcase
  end

  // Configuration, state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      variant         <= VAR_206;
      chr_size_log2   <= 5'd17;
      prg_size_log2   <= 5'd17;
      prg_ram_present <= 1'b0;
      bank_select     <= '0;
      chr_bank        <= '{default: '0};
      prg_bank        <= '{default: '0};
      chr_upper       <= '0;
      nt_select       <= '0;
      mirror_state    <= MIR_VERTICAL;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VARIANT:         variant         <= cfg_data[2:0];
          CFG_CHR_SIZE_LOG2:   chr_size_log2   <= cfg_data;
          CFG_PRG_SIZE_LOG2:   prg_size_log2   <= cfg_data;
          CFG_PRG_RAM_PRESENT: prg_ram_present <= cfg_data[0];
          default:             variant         <= variant;
        endcase
      end
      if (cmd.commit) begin
        bank_select  <= bank_select_next;
        chr_bank     <= chr_bank_next;
        prg_bank     <= prg_bank_next;
        chr_upper    <= chr_upper_next;
        nt_select    <= nt_select_next;
        mirror_state <= mirror_state_next;
        out_valid    <= 1'b1;
      end else if (out_ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_cmd  <= command;
      it_addr <= address;
      it_data <= data;
    end
    if (cmd.commit) begin
      rom_offset       <= off;
      target           <= tgt;
      mirror_mode      <= (v == VAR_95) ? MIR_CUSTOM : mirror_state_next;
      nt_top_select    <= nt_select_next[0];
      nt_bottom_select <= nt_select_next[1];
    end
  end

endmodule

FILE: hdl/bank_switch_cartridge_mapper_unit.sv
// ---------------------------------------------------------------------------
// Bank switch cartridge mapper unit
// 206-family bank mapper: CPU writes load bank registers, CPU/PPU reads are
// translated to a ROM or RAM byte offset.
// ---------------------------------------------------------------------------
//  channel   | dir | payload
//  request   | in  | command, address, data
//  response  | out | rom_offset, target, mirror_mode, nt_top/bottom_select
//  cfg       | in  | cfg_we, cfg_index, cfg_data (write only)
//
// Each item is latched in ST_IDLE, then decoded and translated in ST_EXEC,
// which commits state and loads the result register.
// A waiting result does not block the next item from being latched; the
// commit stalls only while the result register is full and not taken.
// Reset is synchronous and restores the configuration and all bank state.
// ---------------------------------------------------------------------------
module bank_switch_cartridge_mapper_unit (
  input  logic       clk,
  input  logic       rst,
  bscm_req_if.sink   request,
  bscm_rsp_if.source response,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);
  import bscm_pkg::*;

  ctl_cmd_t    ctl_cmd;
  ctl_status_t ctl_status;

  bscm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .status   (ctl_status),
    .cmd      (ctl_cmd)
  );

  bscm_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (ctl_cmd),
    .status           (ctl_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .command          (request.command),
    .address          (request.address),
    .data             (request.data),
    .out_valid        (response.valid),
    .out_ready        (response.ready),
    .rom_offset       (response.rom_offset),
    .target           (response.target),
    .mirror_mode      (response.mirror_mode),
    .nt_top_select    (response.nt_top_select),
    .nt_bottom_select (response.nt_bottom_select)
  );

  `include "bank_switch_cartridge_mapper_unit_macros.svh"

  // One item in flight: no new item right after one is latched
  `BSCM_ASSERT_NEXT(a_one_in_flight, request.valid && request.ready, !request.ready, "item latched while busy")

  // A commit always leaves a result waiting
  `BSCM_ASSERT_NEXT(a_commit_loads, ctl_cmd.commit, response.valid, "commit lost result")

  // Unmapped results carry a zero offset
  `BSCM_ASSERT_NOW(a_none_zero, response.valid && response.target == TGT_NONE, response.rom_offset == '0, "unmapped offset not zero")

  // Program RAM offsets stay inside the 8 KB window
  `BSCM_ASSERT_NOW(a_ram_window, response.valid && response.target == TGT_PRG_RAM, response.rom_offset[ROM_OFFSET_BITS-1:13] == '0, "RAM offset beyond 8 KB")

endmodule

FILE: dv/bank_switch_cartridge_mapper_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bank switch cartridge mapper unit: testbench
// Runs bus writes and CPU/PPU read translations through the mapper on every
// board variant with fixed and random ROM sizes. A local bank-register model predicts
// each response, and the responses are checked in order, field by field.
// ---------------------------------------------------------------------------
module bank_switch_cartridge_mapper_unit_tb;
  import bscm_pkg::*;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
  } access_t;

  typedef struct packed {
    offset_t    offset;
    logic [1:0] target;
    logic [2:0] mirror;
    logic       nt_top;
    logic       nt_bottom;
  } xlat_result_t;

  localparam int MAX_REPORTS = 200;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_data;

  bscm_req_if req_ch ();
  bscm_rsp_if rsp_ch ();

  bank_switch_cartridge_mapper_unit dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Stimulus and expected translations
  access_t      access_q[$];
  xlat_result_t predicted_xlat_q[$];
  int           pushed_items;
  int           xlat_errors;
  int           gap_pct;
  int           stall_pct;
  int           gap_left;
  int           stall_left;
  access_t      drive_item;

  // Shadow configuration
  logic [2:0] cfg_variant;
  logic [4:0] cfg_chr_lg;
  logic [4:0] cfg_prg_lg;
  logic       cfg_ram;

  // Shadow bank state
  logic [2:0] sel_reg;
  logic [8:0] chr_bank_q [6];
  logic [7:0] prg_bank_q [2];
  logic [3:0] chr_hi_q;
  logic [1:0] nt_sel_q;
  logic [2:0] mirror_q;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [2:0] board();
    return (cfg_variant > VAR_154) ? VAR_206 : cfg_variant;
  endfunction

  // Address mask for a ROM of 2**lg bytes, lg clamped
  function automatic logic [31:0] rom_mask(input logic [4:0] lg, input int unsigned floor_lg);
    int unsigned n;
    n = lg;
    if (n < floor_lg) n = floor_lg;
    if (n > ROM_OFFSET_BITS) n = ROM_OFFSET_BITS;
    return (32'd1 << n) - 32'd1;
  endfunction

  // Load the register picked by the last select write
  function automatic void load_bank(input logic [2:0] v, input logic [7:0] val);
    int s;
    s = sel_reg;
    if (v == VAR_112) begin
      if (s < 2) prg_bank_q[s] = val;
      else if (s < 4) chr_bank_q[s-2] = {1'b0, val[7:1], 1'b0};
      else chr_bank_q[s-2] = {chr_hi_q[s-4], val};
    end else if (s >= 6) begin
      prg_bank_q[s-6] = val;
    end else if (v == VAR_76) begin
      // selects 0 and 1 are unused on this board
      if (s >= 2) chr_bank_q[s] = {val, 1'b0};
    end else if (v == VAR_88 || v == VAR_154) begin
      chr_bank_q[s] = (s < 2) ? {3'b000, val[5:1], 1'b0} : {1'b0, val | 8'h40};
    end else begin
      chr_bank_q[s] = (s < 2) ? {1'b0, val[7:1], 1'b0} : {1'b0, val};
      if (v == VAR_95 && s < 2) nt_sel_q[s] = val[5];
    end
  endfunction

  // Apply one access to the shadow state and return the expected response
  function automatic xlat_result_t map_access(input logic [1:0] cmd, input logic [15:0] addr,
                                              input logic [7:0] dat);
    xlat_result_t res;
    logic [2:0]   v;
    logic [15:0]  port;
    logic [31:0]  msk;
    logic [31:0]  base;
    logic [31:0]  off;
    logic [8:0]   bank;
    logic [10:0]  low;
    logic [1:0]   tgt;
    logic [1:0]   q;
    v   = board();
    off = '0;
    tgt = TGT_NONE;
    case (cmd)
      CMD_WRITE: begin
        port = addr & PORT_MASK;
        if (port == PORT_SELECT) sel_reg = dat[2:0];
        if (v == VAR_112) begin
          if (port == PORT_A000) load_bank(v, dat);
          else if (port == PORT_C000) chr_hi_q = dat[7:4];
          else if (port == PORT_E000) mirror_q = dat[0] ? MIR_HORIZONTAL : MIR_VERTICAL;
        end else begin
          if (port == PORT_DATA) load_bank(v, dat);
          if (v == VAR_154 && addr >= 16'h8000)
            mirror_q = dat[6] ? MIR_SINGLE_UPPER : MIR_SINGLE_LOWER;
        end
      end
      CMD_CPU_READ: begin
        if (addr >= 16'h8000) begin
          msk = rom_mask(cfg_prg_lg, 14);
          q   = addr[14:13];
          // two switchable banks, then the last two banks of the ROM
          if (q < 2'd2) base = 32'(prg_bank_q[q]) << 13;
          else base = (msk + 32'd1) - ((q == 2'd2) ? 32'(PRG_FIX_LOW) : 32'(PRG_FIX_HIGH));
          off = (base + 32'(addr[12:0])) & msk;
          tgt = TGT_PRG_ROM;
        end else if (addr >= 16'h6000 && v == VAR_112 && cfg_ram) begin
          off = 32'(addr[12:0]);
          tgt = TGT_PRG_RAM;
        end
      end
      CMD_PPU_READ: begin
        if (addr < 16'h2000) begin
          msk = rom_mask(cfg_chr_lg, 10);
          if (v == VAR_76) begin
            bank = chr_bank_q[2 + addr[12:11]];
            low  = addr[10:0];
          end else if (addr < 16'h1000) begin
            bank = chr_bank_q[addr[11]];
            low  = addr[10:0];
          end else begin
            bank = chr_bank_q[2 + addr[11:10]];
            low  = {1'b0, addr[9:0]};
          end
          off = ((32'(bank) << 10) + 32'(low)) & msk;
          tgt = TGT_CHR_ROM;
        end
      end
      default: ;
    endcase
    res.offset    = off[ROM_OFFSET_BITS-1:0];
    res.target    = tgt;
    res.mirror    = (v == VAR_95) ? MIR_CUSTOM : mirror_q;
    res.nt_top    = nt_sel_q[0];
    res.nt_bottom = nt_sel_q[1];
    return res;
  endfunction

  function automatic void push_access(input logic [1:0] c, input logic [15:0] a,
                                      input logic [7:0] d);
    access_t it;
    it.command = c;
    it.address = a;
    it.data    = d;
    access_q.push_back(it);
    pushed_items++;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 25;
      default: return 50;
    endcase
  endfunction

  // Write a config register while the mapper is idle
  task automatic write_cfg(input logic [1:0] idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_VARIANT:       cfg_variant = val[2:0];
      CFG_CHR_SIZE_LOG2: cfg_chr_lg  = val;
      CFG_PRG_SIZE_LOG2: cfg_prg_lg  = val;
      default:           cfg_ram     = val[0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup_phase(input logic [2:0] v, input logic [4:0] chr_lg,
                             input logic [4:0] prg_lg, input logic ram);
    write_cfg(CFG_VARIANT, {2'b00, v});
    write_cfg(CFG_CHR_SIZE_LOG2, chr_lg);
    write_cfg(CFG_PRG_SIZE_LOG2, prg_lg);
    write_cfg(CFG_PRG_RAM_PRESENT, {4'b0000, ram});
  endtask

  // Hold off until every issued item has its response, plus pipeline slack
  task automatic wait_drained();
    do @(negedge clk);
    while (access_q.size() != 0 || req_ch.valid || predicted_xlat_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  // One random burst: a select/load pair followed by reads, a single register write, a single read or a random access
  task automatic queue_random_sequence();
    int          r;
    int          n;
    logic [15:0] mb;
    mb = 16'($urandom) & 16'h1FFE;
    r  = $urandom_range(99);
    if (r < 40) begin
      push_access(CMD_WRITE, PORT_SELECT | mb, 8'($urandom));
      mb = 16'($urandom) & 16'h1FFE;
      if (board() == VAR_112) push_access(CMD_WRITE, PORT_A000 | mb, 8'($urandom));
      else push_access(CMD_WRITE, PORT_DATA | mb, 8'($urandom));
      n = $urandom_range(1, 3);
      repeat (n) begin
        if ($urandom_range(1)) push_access(CMD_PPU_READ, 16'($urandom_range(16'h1FFF)),
                                           8'($urandom));
        else push_access(CMD_CPU_READ, 16'($urandom_range(16'h6000, 16'hFFFF)),
                         8'($urandom));
      end
    end else if (r < 50) begin
      case ($urandom_range(3))
        0: push_access(CMD_WRITE, PORT_C000 | mb, 8'($urandom));
        1: push_access(CMD_WRITE, PORT_E000 | mb, 8'($urandom));
        2: push_access(CMD_WRITE, PORT_A000 | mb, 8'($urandom));
        default: push_access(CMD_WRITE, PORT_DATA | mb, 8'($urandom));
      endcase
    end else if (r < 70) begin
      push_access(CMD_PPU_READ, 16'($urandom_range(16'h1FFF)), 8'($urandom));
    end else if (r < 85) begin
      push_access(CMD_CPU_READ, 16'($urandom_range(16'h6000, 16'hFFFF)), 8'($urandom));
    end else begin
      push_access(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (xlat_errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      xlat_errors++;
    end
  endtask

  // Request driver: predicts on acceptance, then offers the next item
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left     = 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        predicted_xlat_q.push_back(map_access(req_ch.command, req_ch.address, req_ch.data));
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (access_q.size() != 0) begin
          if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            // insert an idle gap before the next item
            gap_left = $urandom_range(3);
            req_ch.valid <= 1'b0;
          end else begin
            drive_item = access_q.pop_front();
            req_ch.command <= drive_item.command;
            req_ch.address <= drive_item.address;
            req_ch.data    <= drive_item.data;
            req_ch.valid   <= 1'b1;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_xlat_q.size() == 0) begin
          if (xlat_errors < MAX_REPORTS)
            $display("%0t: unexpected response, expected none, actual offset 0x%0h target %0d",
                     $time, rsp_ch.rom_offset, rsp_ch.target);
          xlat_errors++;
        end else begin
          xlat_result_t want;
          want = predicted_xlat_q.pop_front();
          check_field("rom_offset", want.offset, rsp_ch.rom_offset);
          check_field("target", want.target, rsp_ch.target);
          check_field("mirror_mode", want.mirror, rsp_ch.mirror_mode);
          check_field("nt_top_select", want.nt_top, rsp_ch.nt_top_select);
          check_field("nt_bottom_select", want.nt_bottom, rsp_ch.nt_bottom_select);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(3);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    logic [2:0] v;
    logic [4:0] chr_lg;
    logic [4:0] prg_lg;
    logic       ram;
    int         goal;

    // known values on every input, reset state in the shadow model
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_VARIANT;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.command = CMD_WRITE;
    req_ch.address = '0;
    req_ch.data    = '0;
    rsp_ch.ready   = 1'b0;
    pushed_items   = 0;
    xlat_errors    = 0;
    gap_pct        = 30;
    stall_pct      = 30;
    cfg_variant    = VAR_206;
    cfg_chr_lg     = 5'd17;
    cfg_prg_lg     = 5'd17;
    cfg_ram        = 1'b0;
    sel_reg        = '0;
    chr_hi_q       = '0;
    nt_sel_q       = '0;
    mirror_q       = MIR_VERTICAL;
    foreach (chr_bank_q[i]) chr_bank_q[i] = '0;
    foreach (prg_bank_q[i]) prg_bank_q[i] = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration: fixed banks, bank loads, unmapped reads
    push_access(CMD_PPU_READ, 16'h0000, 8'h00);
    push_access(CMD_CPU_READ, 16'hFFFF, 8'hFF);
    push_access(CMD_CPU_READ, 16'hC000, 8'h00);
    push_access(CMD_WRITE,    PORT_SELECT, 8'h07);
    push_access(CMD_WRITE,    PORT_DATA, 8'hFF);
    push_access(CMD_CPU_READ, 16'hA000, 8'h00);
    push_access(CMD_WRITE,    PORT_SELECT, 8'h00);
    push_access(CMD_WRITE,    PORT_DATA, 8'hFF);
    push_access(CMD_PPU_READ, 16'h07FF, 8'h00);
    push_access(CMD_PPU_READ, 16'h2000, 8'h00);
    push_access(CMD_CPU_READ, 16'h7FFF, 8'h00);
    push_access(2'd3,         16'hFFFF, 8'hFF);
    push_access(CMD_WRITE,    16'h6000, 8'hFF);
    wait_drained();

    // 112 board with RAM, sizes saturated at both ends
    setup_phase(VAR_112, 5'd0, 5'd31, 1'b1);
    push_access(CMD_WRITE,    PORT_C000, 8'hF0);
    push_access(CMD_WRITE,    PORT_SELECT, 8'h04);
    push_access(CMD_WRITE,    PORT_A000, 8'hFF);
    push_access(CMD_PPU_READ, 16'h1000, 8'h00);
    push_access(CMD_CPU_READ, 16'h6000, 8'h00);
    push_access(CMD_WRITE,    PORT_E000, 8'h01);
    wait_drained();

    // 76 board: unused select is ignored
    setup_phase(VAR_76, 5'd19, 5'd21, 1'b0);
    push_access(CMD_WRITE,    PORT_SELECT, 8'h01);
    push_access(CMD_WRITE,    PORT_DATA, 8'hFF);
    push_access(CMD_PPU_READ, 16'h1FFF, 8'h00);
    wait_drained();

    // 154 board: any high write sets single-screen mirroring
    setup_phase(VAR_154, 5'd10, 5'd14, 1'b0);
    push_access(CMD_WRITE, 16'hFFFF, 8'h40);
    wait_drained();

    // Random phases over all variants and sizes; the last one runs without idling
    for (int ph = 0; ph < 18; ph++) begin
      if (ph < 8) v = 3'(ph);
      else if (ph == 8) v = VAR_112;
      else v = 3'($urandom_range(7));
      case (ph % 4)
        0: begin
          chr_lg = 5'd10;
          prg_lg = 5'd21;
        end
        1: begin
          chr_lg = 5'd19;
          prg_lg = 5'd14;
        end
        default: begin
          chr_lg = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(10, 19));
          prg_lg = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(14, 21));
        end
      endcase
      if (ph == 8) ram = 1'b0;
      else if (v == VAR_112 && ph < 8) ram = 1'b1;
      else ram = 1'($urandom_range(1));

      gap_pct   = (ph == 17) ? 0 : pick_idle_pct();
      stall_pct = (ph == 17) ? 0 : pick_idle_pct();
      setup_phase(v, chr_lg, prg_lg, ram);
      goal = pushed_items + 92;
      while (pushed_items < goal) queue_random_sequence();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (xlat_errors == 0 && predicted_xlat_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
